// ===== rtl/core/rau_pkg.sv =====
// Shared types and codes for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

    localparam int FIELD_W = 32;  // operand and result numerator field width
    localparam int DEN_W   = 31;  // result denominator field width

    typedef enum logic [2:0] {
        CMD_REDUCE,
        CMD_ADD,
        CMD_SUB,
        CMD_MUL,
        CMD_DIV,
        CMD_NEG,
        CMD_ABS,
        CMD_EQ
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK,
        ST_ERR,
        ST_OVF
    } t_status;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_Q,
        MUL_D
    } t_mul_step;

    typedef enum logic {
        DIV_NUM,
        DIV_DEN
    } t_div_sel;

    // controller -> datapath
    typedef struct packed {
        logic      load;
        logic      mul_en;
        t_mul_step mul_step;
        logic      comb;
        logic      gcd_step;
        logic      div_init;
        logic      div_step;
        logic      div_store;
        t_div_sel  div_sel;
        logic      out_ok;
        logic      out_err;
    } t_dp_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic bad;
        logic gcd_done;
        logic div_done;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== rtl/core/rau_in_if.sv =====
// Input channel: command and two fractions.
`default_nettype none
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;

    modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rau_out_if.sv =====
// Output channel: reduced result fraction and status.
`default_nettype none
interface rau_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic        is_equal;
    logic [1:0]  status;

    modport source (output valid, res_num, res_den, is_equal, status, input ready);
    modport sink   (input valid, res_num, res_den, is_equal, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rau_dp.sv =====
// Datapath: operand split, shared multiplier, binary gcd and restoring divider.
`default_nettype none
module rau_dp #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire rau_pkg::t_dp_ctrl i_ctrl,
    output rau_pkg::t_dp_stat      o_stat,
    input  wire logic [2:0]        i_command,
    input  wire logic signed [31:0] i_a_num,
    input  wire logic signed [31:0] i_a_den,
    input  wire logic signed [31:0] i_b_num,
    input  wire logic signed [31:0] i_b_den,
    output logic signed [31:0]     o_res_num,
    output logic [30:0]            o_res_den,
    output logic                   o_is_equal,
    output logic [1:0]             o_status
);
    localparam int W  = OPERAND_WIDTH;
    localparam int NW = 2 * W;
    localparam int KW = $clog2(NW + 1);
    localparam logic [NW-1:0] LIMIT = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};

    // {sign, magnitude} of the low W bits
    function automatic logic [W:0] split(input logic [31:0] raw);
        logic [W-1:0] v;
        v = raw[W-1:0];
        return v[W-1] ? {1'b1, (~v) + W'(1)} : {1'b0, v};
    endfunction

    logic [W:0] an_s, ad_s, bn_s, bd_s;
    rau_pkg::t_cmd cmd_in;
    logic uses_b_in;

    rau_pkg::t_cmd r_cmd;
    logic [W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic          r_a_neg, r_b_neg, r_bad;
    logic [NW-1:0] r_p, r_q, r_d, r_n;
    logic          r_neg, r_eq;
    logic [NW-1:0] r_x, r_y;
    logic [KW-1:0] r_k;
    logic [NW-1:0] r_g, r_rem, r_quo;
    logic [KW-1:0] r_dcnt;
    logic signed [31:0] r_res_num;
    logic [30:0]   r_res_den;
    logic          r_is_equal;
    logic [1:0]    r_status;

    logic          unary;
    logic [W-1:0]  m_x, m_y;
    logic [NW-1:0] m_prod;
    logic [NW-1:0] c_n, c_d;
    logic          c_neg, c_eq, sb;
    logic [NW:0]   rem_sh;
    logic          q_bit;
    logic [NW-1:0] rem_nx;
    logic [31:0]   mag32;

    always_comb begin
        an_s      = split(i_a_num);
        ad_s      = split(i_a_den);
        bn_s      = split(i_b_num);
        bd_s      = split(i_b_den);
        cmd_in    = rau_pkg::t_cmd'(i_command);
        uses_b_in = !(cmd_in inside {rau_pkg::CMD_REDUCE, rau_pkg::CMD_NEG, rau_pkg::CMD_ABS});
    end

    assign unary = r_cmd inside {rau_pkg::CMD_REDUCE, rau_pkg::CMD_NEG, rau_pkg::CMD_ABS};

    // shared W x W multiplier
    always_comb begin
        case (i_ctrl.mul_step)
            rau_pkg::MUL_P: begin
                m_x = r_an;
                m_y = (r_cmd == rau_pkg::CMD_MUL) ? r_bn : (unary ? W'(1) : r_bd);
            end
            rau_pkg::MUL_Q: begin
                m_x = r_bn;
                m_y = r_ad;
            end
            default: begin
                m_x = r_ad;
                m_y = (r_cmd == rau_pkg::CMD_DIV) ? r_bn : (unary ? W'(1) : r_bd);
            end
        endcase
    end
    assign m_prod = m_x * m_y;

    // combine cross products into the unreduced result
    always_comb begin
        c_n   = r_p;
        c_d   = r_d;
        c_neg = r_a_neg;
        c_eq  = 1'b0;
        sb    = 1'b0;
        case (r_cmd)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                sb = (r_cmd == rau_pkg::CMD_SUB) ? ((r_bn != '0) && !r_b_neg) : r_b_neg;
                if (r_a_neg == sb) begin
                    c_n = r_p + r_q;
                end else if (r_p >= r_q) begin
                    c_n = r_p - r_q;
                end else begin
                    c_n   = r_q - r_p;
                    c_neg = sb;
                end
            end
            rau_pkg::CMD_MUL, rau_pkg::CMD_DIV: c_neg = r_a_neg ^ r_b_neg;
            rau_pkg::CMD_NEG: c_neg = !r_a_neg;
            rau_pkg::CMD_ABS: c_neg = 1'b0;
            rau_pkg::CMD_EQ: begin
                c_eq  = (r_a_neg == r_b_neg) && (r_p == r_q);
                c_n   = {{(NW-1){1'b0}}, c_eq};
                c_d   = {{(NW-1){1'b0}}, 1'b1};
                c_neg = 1'b0;
            end
            default: c_neg = r_a_neg;
        endcase
    end

    // one restoring division step
    always_comb begin
        rem_sh = {r_rem, r_quo[NW-1]};
        q_bit  = rem_sh >= {1'b0, r_g};
        rem_nx = q_bit ? NW'(rem_sh - {1'b0, r_g}) : rem_sh[NW-1:0];
    end

    assign mag32 = 32'(r_n);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= cmd_in;
            r_an    <= an_s[W-1:0];
            r_ad    <= ad_s[W-1:0];
            r_bn    <= bn_s[W-1:0];
            r_bd    <= bd_s[W-1:0];
            r_a_neg <= (an_s[W-1:0] != '0) && (an_s[W] ^ ad_s[W]);
            r_b_neg <= (bn_s[W-1:0] != '0) && (bn_s[W] ^ bd_s[W]);
            r_bad   <= (ad_s[W-1:0] == '0)
                    || (uses_b_in && (bd_s[W-1:0] == '0))
                    || ((cmd_in == rau_pkg::CMD_DIV) && (bn_s[W-1:0] == '0));
        end
        if (i_ctrl.mul_en) begin
            case (i_ctrl.mul_step)
                rau_pkg::MUL_P: r_p <= m_prod;
                rau_pkg::MUL_Q: r_q <= m_prod;
                default:        r_d <= m_prod;
            endcase
        end
        if (i_ctrl.comb) begin
            r_n   <= c_n;
            r_d   <= c_d;
            r_neg <= c_neg;
            r_eq  <= c_eq;
            r_x   <= c_n;
            r_y   <= c_d;
            r_k   <= '0;
        end
        // binary gcd, one step a cycle
        if (i_ctrl.gcd_step && (r_x != '0)) begin
            if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + KW'(1);
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x >= r_y) begin
                r_x <= r_x - r_y;
            end else begin
                r_y <= r_y - r_x;
            end
        end
        if (i_ctrl.div_init) begin
            r_g    <= r_y << r_k;
            r_rem  <= '0;
            r_quo  <= (i_ctrl.div_sel == rau_pkg::DIV_NUM) ? r_n : r_d;
            r_dcnt <= '0;
        end
        if (i_ctrl.div_step) begin
            r_rem  <= rem_nx;
            r_quo  <= {r_quo[NW-2:0], q_bit};
            r_dcnt <= r_dcnt + KW'(1);
        end
        if (i_ctrl.div_store) begin
            if (i_ctrl.div_sel == rau_pkg::DIV_NUM) begin
                r_n <= r_quo;
            end else begin
                r_d <= r_quo;
            end
        end
        if (i_ctrl.out_ok) begin
            if ((r_n > LIMIT) || (r_d > LIMIT)) begin
                r_res_num  <= '0;
                r_res_den  <= '0;
                r_is_equal <= 1'b0;
                r_status   <= rau_pkg::ST_OVF;
            end else begin
                r_res_num  <= r_neg ? -$signed(mag32) : $signed(mag32);
                r_res_den  <= 31'(r_d);
                r_is_equal <= r_eq;
                r_status   <= rau_pkg::ST_OK;
            end
        end else if (i_ctrl.out_err) begin
            r_res_num  <= '0;
            r_res_den  <= '0;
            r_is_equal <= 1'b0;
            r_status   <= rau_pkg::ST_ERR;
        end
    end

    assign o_stat.bad      = r_bad;
    assign o_stat.gcd_done = (r_x == '0);
    assign o_stat.div_done = (r_dcnt == KW'(NW));

    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_is_equal = r_is_equal;
    assign o_status   = r_status;

endmodule
`default_nettype wire

// ===== rtl/core/rau_ctrl.sv =====
// Controller: sequences load, multiply, gcd, divide and result hand-off.
`default_nettype none
module rau_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire rau_pkg::t_dp_stat i_stat,
    output rau_pkg::t_dp_ctrl      o_ctrl
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_MP, S_MQ, S_MD, S_COMB, S_GCD,
        S_DNI, S_DN, S_DDI, S_DD, S_FIN, S_ERR
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                o_ctrl.load = i_in_valid;
                if (i_in_valid) n_state = S_CHK;
            end
            S_CHK: n_state = i_stat.bad ? S_ERR : S_MP;
            S_MP: begin
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mul_step = rau_pkg::MUL_P;
                n_state         = S_MQ;
            end
            S_MQ: begin
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mul_step = rau_pkg::MUL_Q;
                n_state         = S_MD;
            end
            S_MD: begin
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mul_step = rau_pkg::MUL_D;
                n_state         = S_COMB;
            end
            S_COMB: begin
                o_ctrl.comb = 1'b1;
                n_state     = S_GCD;
            end
            S_GCD: begin
                if (i_stat.gcd_done) n_state = S_DNI;
                else o_ctrl.gcd_step = 1'b1;
            end
            S_DNI: begin
                o_ctrl.div_init = 1'b1;
                o_ctrl.div_sel  = rau_pkg::DIV_NUM;
                n_state         = S_DN;
            end
            S_DN: begin
                o_ctrl.div_sel = rau_pkg::DIV_NUM;
                if (i_stat.div_done) begin
                    o_ctrl.div_store = 1'b1;
                    n_state          = S_DDI;
                end else begin
                    o_ctrl.div_step = 1'b1;
                end
            end
            S_DDI: begin
                o_ctrl.div_init = 1'b1;
                o_ctrl.div_sel  = rau_pkg::DIV_DEN;
                n_state         = S_DD;
            end
            S_DD: begin
                o_ctrl.div_sel = rau_pkg::DIV_DEN;
                if (i_stat.div_done) begin
                    o_ctrl.div_store = 1'b1;
                    n_state          = S_FIN;
                end else begin
                    o_ctrl.div_step = 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_ctrl.out_ok = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    o_ctrl.out_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctrl.out_ok || o_ctrl.out_err) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Top level: rational arithmetic unit with gcd-reduced results.
//
//  channel | dir | payload                                   | handshake
//  i_in    | in  | command, a_num, a_den, b_num, b_den       | valid/ready
//  o_out   | out | res_num, res_den, is_equal, status        | valid/ready
//
// One item at a time. An item forms three cross products in turn on one
// shared W x W multiplier, runs one binary-gcd step per cycle, then does
// two restoring divisions by the gcd. Error items skip the products, gcd
// and divisions and go straight to the output register.
// Reset is synchronous and clears the controller and the output valid flag.
// The result sits in an output register; the next item is taken while it
// waits, and a finished item stalls only if that register is still full.
`default_nettype none
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    rau_pkg::t_dp_ctrl ctrl;
    rau_pkg::t_dp_stat stat;

    // sequencing
    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    // arithmetic, gcd and division; also holds the output register
    rau_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .i_command  (i_in.command),
        .i_a_num    (i_in.a_num),
        .i_a_den    (i_in.a_den),
        .i_b_num    (i_in.b_num),
        .i_b_den    (i_in.b_den),
        .o_res_num  (o_out.res_num),
        .o_res_den  (o_out.res_den),
        .o_is_equal (o_out.is_equal),
        .o_status   (o_out.status)
    );

endmodule
`default_nettype wire

// ===== rtl/core/rau_chk.sv =====
// Port-level checks for the rational arithmetic unit, bound to the top level.
`default_nettype none
module rau_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_res_num,
    input wire logic [30:0] i_res_den,
    input wire logic        i_is_equal,
    input wire logic [1:0]  i_status
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_res_num)
            && $stable(i_res_den) && $stable(i_status))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("accepted a second item while busy");

    // failed results carry zero fields, ok results a positive denominator
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_status == rau_pkg::ST_OK) ? (i_res_den != '0)
            : (i_res_num == '0 && i_res_den == '0 && !i_is_equal)))
        else $error("result fields do not match status");

    // equality result is 1/1
    a_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_equal |-> i_res_num == 32'd1 && i_res_den == 31'd1)
        else $error("equal flag without 1/1");

endmodule

bind rational_arithmetic_unit rau_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_res_num   (o_out.res_num),
    .i_res_den   (o_out.res_den),
    .i_is_equal  (o_out.is_equal),
    .i_status    (o_out.status)
);
`default_nettype wire

// ===== tb/rau_tb_checker.sv =====
// Checker: watches both channels, predicts each result and compares it.
`default_nettype none
module rau_tb_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rau_in_if.sink    i_mon_in,
    rau_out_if.sink   i_mon_out,
    output int        o_fail_count,
    output int        o_pending
);
    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               eq;
        rau_pkg::t_status   status;
    } t_result;

    typedef struct {
        bit          neg;
        logic [63:0] n;
        logic [63:0] d;
    } t_frac;

    t_result results_due[$];
    int      fails;

    assign o_fail_count = fails;
    assign o_pending    = results_due.size();

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_frac normalize(t_frac f);
        logic [63:0] g;
        g = gcd64(f.d, f.n);
        if (g == 0) g = 1;
        f.n = f.n / g;
        f.d = f.d / g;
        if (f.n == 0) begin
            f.neg = 0;
            f.d   = 1;
        end
        return f;
    endfunction

    // sign and magnitude of a 32-bit operand; the most negative value is exact
    function automatic void to_mag(logic [31:0] v, output bit neg, output logic [63:0] m);
        neg = v[31];
        m   = v[31] ? 64'(-{1'b1, v}) & 64'hFFFF_FFFF : 64'(v);
        if (v[31]) m = 64'(33'h1_0000_0000 - {1'b0, v});
    endfunction

    function automatic bit build(logic [31:0] rn, logic [31:0] rd, output t_frac f);
        bit          sn, sd;
        logic [63:0] mn, md;
        to_mag(rn, sn, mn);
        to_mag(rd, sd, md);
        f.neg = 0; f.n = 0; f.d = 1;
        if (md == 0) return 0;
        f.neg = (mn != 0) && (sn != sd);
        f.n   = mn;
        f.d   = md;
        f     = normalize(f);
        return 1;
    endfunction

    function automatic t_result fraction_result(rau_pkg::t_cmd cmd, logic [31:0] an,
                                                logic [31:0] ad, logic [31:0] bn,
                                                logic [31:0] bd);
        t_frac       a, b, r;
        t_result     res;
        bit          sb, uses_b;
        logic [63:0] p, q;
        logic        eq;
        res    = '{num: 0, den: 0, eq: 0, status: rau_pkg::ST_ERR};
        eq     = 0;
        uses_b = !(cmd inside {rau_pkg::CMD_REDUCE, rau_pkg::CMD_NEG, rau_pkg::CMD_ABS});
        if (!build(an, ad, a)) return res;
        b.neg = 0; b.n = 0; b.d = 1;
        if (uses_b && !build(bn, bd, b)) return res;
        r = a;
        case (cmd)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                sb  = (cmd == rau_pkg::CMD_SUB) ? (b.n != 0 && !b.neg) : b.neg;
                p   = a.n * b.d;
                q   = b.n * a.d;
                r.d = a.d * b.d;
                if (a.neg == sb) begin
                    r.n = p + q; r.neg = a.neg;
                end else if (p >= q) begin
                    r.n = p - q; r.neg = a.neg;
                end else begin
                    r.n = q - p; r.neg = sb;
                end
            end
            rau_pkg::CMD_MUL: begin
                r.n = a.n * b.n; r.d = a.d * b.d; r.neg = a.neg != b.neg;
            end
            rau_pkg::CMD_DIV: begin
                if (b.n == 0) return res;
                r.n = a.n * b.d; r.d = a.d * b.n; r.neg = a.neg != b.neg;
            end
            rau_pkg::CMD_NEG: r.neg = !a.neg;
            rau_pkg::CMD_ABS: r.neg = 0;
            rau_pkg::CMD_EQ: begin
                eq = (a.neg == b.neg && a.n == b.n && a.d == b.d);
                r.neg = 0; r.n = 64'(eq); r.d = 1;
            end
            default: ;
        endcase
        r = normalize(r);
        if (r.n > 64'h7FFF_FFFF || r.d > 64'h7FFF_FFFF) begin
            res.status = rau_pkg::ST_OVF;
            return res;
        end
        res.num    = r.neg ? -32'(r.n) : 32'(r.n);
        res.den    = 31'(r.d);
        res.eq     = eq;
        res.status = rau_pkg::ST_OK;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            fails <= 0;
        end else begin
            if (i_mon_in.valid && i_mon_in.ready)
                results_due.push_back(fraction_result(rau_pkg::t_cmd'(i_mon_in.command),
                    i_mon_in.a_num, i_mon_in.a_den, i_mon_in.b_num, i_mon_in.b_den));
            if (i_mon_out.valid && i_mon_out.ready) begin
                if (results_due.size() == 0) begin
                    $error("result with nothing expected");
                    fails <= fails + 1;
                end else begin
                    want = results_due.pop_front();
                    if (want.num !== i_mon_out.res_num) begin
                        $error("res_num expected %0d actual %0d", want.num, i_mon_out.res_num);
                        fails <= fails + 1;
                    end else if (want.den !== i_mon_out.res_den) begin
                        $error("res_den expected %0d actual %0d", want.den, i_mon_out.res_den);
                        fails <= fails + 1;
                    end else if (want.eq !== i_mon_out.is_equal) begin
                        $error("is_equal expected %0d actual %0d", want.eq,
                               i_mon_out.is_equal);
                        fails <= fails + 1;
                    end else if (want.status !== i_mon_out.status) begin
                        $error("status expected %0d actual %0d", want.status,
                               i_mon_out.status);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_rational_arithmetic_unit.sv =====
// Testbench top: clock, reset, stimulus, receiver stalls and verdict.
`default_nettype none
module tb_rational_arithmetic_unit;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 950;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   fail_count, pending, idle_cycles;
    bit   long_hold = 0;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_arithmetic_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rau_tb_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mon_in     (in_ch.sink),
        .i_mon_out    (out_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // watchdog: cycles with no accepted item on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: own stall pattern, one long hold-off early in the random part
    initial begin
        int mode;
        out_ch.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_ch.ready <= 0;
                repeat (3000) @(negedge i_clk);
                long_hold = 0;
            end
            mode = $urandom_range(0, 15);
            out_ch.ready <= (mode < 6) ? 1'b1 : (mode < 12) ? ($urandom_range(0, 3) != 0)
                                                             : ($urandom_range(0, 3) == 0);
        end
    end

    // operand value: small most often, some extremes, some fully random, some shifted
    function automatic logic [31:0] pick_value(bit allow_zero);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0001;
            3, 4: v = $urandom;
            5: v = $urandom_range(0, 65535) << $urandom_range(0, 15);
            default: v = $urandom_range(0, 200) - 100;
        endcase
        if (v == 0 && !allow_zero && $urandom_range(0, 3) != 0) v = 1;
        return v;
    endfunction

    task automatic send(rau_pkg::t_cmd cmd, logic [31:0] an, logic [31:0] ad,
                        logic [31:0] bn, logic [31:0] bd);
        in_ch.valid   <= 1;
        in_ch.command <= cmd;
        in_ch.a_num   <= an;
        in_ch.a_den   <= ad;
        in_ch.b_num   <= bn;
        in_ch.b_den   <= bd;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    initial begin
        int burst;
        logic [31:0] base_num, base_den;
        in_ch.valid = 0; in_ch.command = rau_pkg::CMD_REDUCE;
        in_ch.a_num = 0; in_ch.a_den = 1; in_ch.b_num = 0; in_ch.b_den = 1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: every command, extremes, zero denominators, divide by zero
        for (int c = 0; c < 8; c++)
            send(rau_pkg::t_cmd'(c), 6, -4, 32'h8000_0000, 32'h7FFF_FFFF);
        send(rau_pkg::CMD_REDUCE, 0, -7, 0, 0);
        send(rau_pkg::CMD_NEG, 5, 0, 1, 1);
        send(rau_pkg::CMD_ADD, 1, 2, 1, 0);
        send(rau_pkg::CMD_DIV, 3, 4, 0, 5);
        send(rau_pkg::CMD_ABS, 32'h8000_0000, 1, 0, 0);
        send(rau_pkg::CMD_NEG, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
        send(rau_pkg::CMD_MUL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
        send(rau_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send(rau_pkg::CMD_SUB, 32'h8000_0000, 1, 32'h8000_0000, 1);
        send(rau_pkg::CMD_EQ, 2, -4, -1, 2);
        send(rau_pkg::CMD_EQ, 0, 3, 0, -9);
        send(rau_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001);
        send(rau_pkg::CMD_SUB, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE);
        in_ch.valid <= 0;

        long_hold = 1;
        for (int i = 0; i < RANDOM_ITEMS;) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && i < RANDOM_ITEMS; k++, i++) begin
                base_num = pick_value(1);
                base_den = pick_value($urandom_range(0, 15) == 0);
                if ($urandom_range(0, 3) == 0)  // equal or scaled operands
                    send(rau_pkg::t_cmd'($urandom_range(0, 7)), base_num, base_den,
                         base_num * 3, base_den * 3);
                else
                    send(rau_pkg::t_cmd'($urandom_range(0, 7)), base_num, base_den,
                         pick_value(1), pick_value($urandom_range(0, 15) == 0));
            end
            if ($urandom_range(0, 2) != 0) begin
                in_ch.valid <= 0;
                repeat ($urandom_range(1, 400)) @(negedge i_clk);
            end
        end
        in_ch.valid <= 0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== rational_arithmetic_unit.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_in_if.sv
rtl/core/rau_out_if.sv
rtl/core/rau_dp.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arithmetic_unit.sv
rtl/core/rau_chk.sv
tb/rau_tb_checker.sv
tb/tb_rational_arithmetic_unit.sv
